FILE: sv/satc_pkg.sv
// ----------------------------------------------------------------------------
// satc_pkg: shared types and constants for the set-associative tag store
// Holds payload structs, default sizes, register indexes and outcome codes.
// ----------------------------------------------------------------------------
package satc_pkg;

    localparam int DEF_SETS      = 64;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_ADDR_BITS = 48;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETB   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFB   = 2'd3;

    localparam logic [1:0] OUT_READ_MISS  = 2'd0;
    localparam logic [1:0] OUT_READ_HIT   = 2'd1;
    localparam logic [1:0] OUT_WRITE_MISS = 2'd2;
    localparam logic [1:0] OUT_WRITE_HIT  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [47:0] address;
    } req_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] mem_read_total;
        logic [31:0] mem_write_total;
    } rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic clear;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
    } stat_t;

endpackage

FILE: sv/set_assoc_tag_store_fifo_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_store_fifo_lru: cache tag store with FIFO or LRU replacement
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  satc_pkg::req_t
//   rsp       out        rsp_valid/rsp_stall  satc_pkg::rsp_t
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// For each item the set row is read from the set memory in the
// accept cycle and written back with new tags and ages in the next.
// After reset a clearing pass writes one set row per cycle until every set
// is cleared; no item is accepted during it. A held result blocks the next
// item only until it is taken, and no item is accepted during a write-back.
// ----------------------------------------------------------------------------
module set_assoc_tag_store_fifo_lru #(
    parameter int SETS      = satc_pkg::DEF_SETS,
    parameter int WAYS      = satc_pkg::DEF_WAYS,
    parameter int ADDR_BITS = satc_pkg::DEF_ADDR_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [satc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [satc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  satc_pkg::req_t                  req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output satc_pkg::rsp_t                  rsp
);
    import satc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    satc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    satc_dp #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: sv/satc_ctrl.sv
// ----------------------------------------------------------------------------
// satc_ctrl: access sequencer
// Runs the clearing pass after reset, then read and write-back per item,
// and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module satc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output satc_pkg::cmd_t cmd,
    input  satc_pkg::stat_t stat
);
    import satc_pkg::*;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_UPDATE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A new item is taken only when no result is waiting or it leaves now.
    logic can_take;
    assign can_take = (state_reg == S_IDLE) && (!out_valid_reg || !out_stall);

    assign in_stall    = !can_take;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = can_take && in_valid;
    assign cmd.update  = (state_reg == S_UPDATE);
    assign cmd.clear   = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/satc_dp.sv
// ----------------------------------------------------------------------------
// satc_dp: tag store datapath
// Set memory with one row per set, lookup, victim choice, age update and
// the saturating totals.
// ----------------------------------------------------------------------------
module satc_dp #(
    parameter int SETS      = satc_pkg::DEF_SETS,
    parameter int WAYS      = satc_pkg::DEF_WAYS,
    parameter int ADDR_BITS = satc_pkg::DEF_ADDR_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [satc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [satc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  satc_pkg::req_t                 req,
    output satc_pkg::rsp_t                 rsp,
    input  satc_pkg::cmd_t                 cmd,
    output satc_pkg::stat_t                stat
);
    import satc_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W = WAY_W;
    localparam int WCNT_W = $clog2(WAYS + 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    typedef struct packed {
        logic             valid;
        logic [AGE_W-1:0] age;
        logic [47:0]      tag;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    // Configuration registers.
    logic       policy_reg;
    logic [3:0] ways_reg;
    logic [2:0] setb_reg;
    logic [3:0] offb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            ways_reg   <= 4'd1;
            setb_reg   <= 3'd2;
            offb_reg   <= 4'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_data[0];
                REG_WAYS:   ways_reg   <= cfg_data;
                REG_SETB:   setb_reg   <= cfg_data[2:0];
                REG_OFFB:   offb_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Address split.
    logic [47:0]      addr;
    logic [47:0]      shifted;
    logic [47:0]      set_full;
    logic [SET_W-1:0] set_idx;
    logic [47:0]      tag_in;

    always_comb
    begin
        addr = req.address;
        if (ADDR_BITS < 48)
        begin
            addr = req.address & ((48'd1 << ADDR_BITS) - 48'd1);
        end
        shifted  = addr >> offb_reg;
        set_full = shifted & ((48'd1 << setb_reg) - 48'd1);
        set_idx  = '0;
        if (SETS > 1 && (SETS & (SETS - 1)) == 0)
        begin
            set_idx = set_full[SET_W-1:0];
        end
        else if (SETS > 1)
        begin
            // The set field is at most 7 bits, so the modulo is a small constant lookup.
            for (int v = 0; v < 128; v++)
            begin
                if (set_full[6:0] == 7'(v))
                begin
                    set_idx = SET_W'(v % SETS);
                end
            end
        end
        tag_in = addr >> (offb_reg + 5'(setb_reg));
    end

    // Set memory and clearing pass.
    row_t             mem [SETS];
    row_t             row_reg;
    logic [SET_W-1:0] set_reg;
    logic [47:0]      tag_reg;
    logic             wr_reg;
    logic [SET_W-1:0] clr_reg;
    logic             clr_done_reg;
    row_t             row_new;
    row_t             row_clear;

    always_comb
    begin
        row_clear = row_new;
        for (int w = 0; w < WAYS; w++)
        begin
            row_clear[w].valid = 1'b0;
            row_clear[w].age   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= mem[set_idx];
            set_reg <= set_idx;
            tag_reg <= tag_in;
            wr_reg  <= req.action;
        end
        if (cmd.clear)
        begin
            mem[clr_reg] <= row_clear;
        end
        else if (cmd.update)
        begin
            mem[set_reg] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            clr_reg      <= clr_reg + 1'b1;
            clr_done_reg <= (clr_reg == SET_W'(SETS - 2)) || (SETS == 1);
        end
    end

    assign stat.clear_done = cmd.clear && (clr_done_reg || clr_reg == SET_W'(SETS - 1));

    // Lookup and replacement on the registered row.
    logic [WCNT_W-1:0] nways;
    logic [WAYS-1:0]   in_use;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              free;
    logic [WAY_W-1:0]  free_way;
    logic [AGE_W-1:0]  best;
    logic [WAY_W-1:0]  vict_way;
    logic [WAY_W-1:0]  way;
    logic [AGE_W:0]    limit;
    logic              touch;

    always_comb
    begin
        nways = (ways_reg == 4'd0) ? WCNT_W'(1)
              : ({1'b0, ways_reg} > 5'(WAYS)) ? WCNT_W'(WAYS) : WCNT_W'(ways_reg);
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        best     = row_reg[0].age;
        vict_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            in_use[w] = (w < int'(nways));
            if (in_use[w] && row_reg[w].valid && row_reg[w].tag == tag_reg)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (in_use[w] && !row_reg[w].valid)
            begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (in_use[w] && row_reg[w].age > best)
            begin
                best     = row_reg[w].age;
                vict_way = WAY_W'(w);
            end
        end
        way   = hit ? hit_way : (free ? free_way : vict_way);
        limit = hit ? {1'b0, row_reg[hit_way].age}
              : (free ? (AGE_W + 1)'(WAYS) : {1'b0, best});
        touch = wr_reg ? (!hit || policy_reg) : (hit && policy_reg);
        row_new = row_reg;
        if (touch)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (WAY_W'(w) == way)
                begin
                    row_new[w].age = '0;
                end
                else if (in_use[w] && row_reg[w].valid
                         && {1'b0, row_reg[w].age} < limit && row_reg[w].age < AGE_MAX)
                begin
                    row_new[w].age = row_reg[w].age + 1'b1;
                end
            end
            if (wr_reg && !hit)
            begin
                row_new[way].valid = 1'b1;
                row_new[way].tag   = tag_reg;
            end
        end
    end

    // Totals and the result register.
    logic [31:0] hit_cnt_reg, miss_cnt_reg, rd_cnt_reg, wrm_cnt_reg;
    logic [1:0]  outcome_reg;
    logic        evicted_reg;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            rd_cnt_reg   <= '0;
            wrm_cnt_reg  <= '0;
        end
        else if (cmd.update)
        begin
            if (!wr_reg && hit)  hit_cnt_reg  <= sat_inc(hit_cnt_reg);
            if (!wr_reg && !hit) miss_cnt_reg <= sat_inc(miss_cnt_reg);
            if (wr_reg && !hit)  rd_cnt_reg   <= sat_inc(rd_cnt_reg);
            if (wr_reg)          wrm_cnt_reg  <= sat_inc(wrm_cnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            outcome_reg <= wr_reg ? (hit ? OUT_WRITE_HIT : OUT_WRITE_MISS)
                                  : (hit ? OUT_READ_HIT : OUT_READ_MISS);
            evicted_reg <= wr_reg && !hit && !free;
        end
    end

    assign rsp.outcome         = outcome_reg;
    assign rsp.evicted         = evicted_reg;
    assign rsp.hit_total       = hit_cnt_reg;
    assign rsp.miss_total      = miss_cnt_reg;
    assign rsp.mem_read_total  = rd_cnt_reg;
    assign rsp.mem_write_total = wrm_cnt_reg;

endmodule

FILE: sv/satc_checker.sv
// ----------------------------------------------------------------------------
// satc_checker: port-level checks for the tag store
// Watches the handshakes and totals on the top-level ports.
// ----------------------------------------------------------------------------
module satc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input satc_pkg::rsp_t rsp
);
    import satc_pkg::*;

    // An accepted item is never accepted back to back.
    a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("item accepted in consecutive cycles");

    // A result becomes valid once its item has passed the update state and the result register.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> ##1 rsp_valid)
        else $error("no result after accepted item");

    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    // Read hit total never falls between results.
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && $past(rsp_valid)) |-> rsp.hit_total >= $past(rsp.hit_total))
        else $error("hit total decreased");

endmodule

bind set_assoc_tag_store_fifo_lru satc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
